### hdl/mrh_pkg.sv
// ----------------------------------------------------------------------------
// mrh_pkg
// shared types, constants and codes of the mersenne 2^61-1 rolling hash table
// ----------------------------------------------------------------------------
package mrh_pkg;

  localparam int MAX_LEN     = 4096;
  localparam int IDX_W       = 13;
  localparam int ADDR_W      = $clog2(MAX_LEN);
  localparam int HASH_W      = 61;
  localparam int HALF_LO_W   = 31;
  localparam int HALF_HI_W   = HASH_W - HALF_LO_W;
  localparam int MID_LO_W    = 30;
  localparam int SYM_W       = 8;
  localparam int FUNC_W      = 2;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [HASH_W-1:0] MOD_P = {HASH_W{1'b1}};

  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

  // steps of the modular multiplier
  localparam logic [2:0] MM_LL   = 3'd0;
  localparam logic [2:0] MM_LH   = 3'd1;
  localparam logic [2:0] MM_HL   = 3'd2;
  localparam logic [2:0] MM_HH   = 3'd3;
  localparam logic [2:0] MM_ACC  = 3'd4;
  localparam logic [2:0] MM_MID  = 3'd5;
  localparam logic [2:0] MM_FOLD = 3'd6;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
  } in_item_t;

  typedef struct packed {
    logic [HASH_W-1:0]   hash_value;
    logic [STATUS_W-1:0] status;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_QUERY,
    CMD_REPLY
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t           kind;
    logic [SYM_W-1:0]    symbol;
    logic [ADDR_W-1:0]   pos;
    logic [IDX_W-1:0]    left;
    logic [IDX_W-1:0]    right;
    logic [IDX_W-1:0]    span;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_sts_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_QREAD,
    BK_QREAD2,
    BK_MUL,
    BK_OUT
  } bk_state_t;

endpackage

### hdl/mrh_ram.sv
// ----------------------------------------------------------------------------
// mrh_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module mrh_ram #(
  parameter int WIDTH = 61,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

endmodule

### hdl/mrh_mulmod.sv
// ----------------------------------------------------------------------------
// mrh_mulmod
// multi-cycle product modulo 2^61-1, one 31x31 partial product per cycle
// ----------------------------------------------------------------------------
module mrh_mulmod (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [mrh_pkg::HASH_W-1:0] a,
  input  logic [mrh_pkg::HASH_W-1:0] b,
  output logic                       done,
  output logic [mrh_pkg::HASH_W-1:0] result
);
  import mrh_pkg::*;

  logic                 busy_r;
  logic [2:0]           step_r;
  logic                 done_r;
  logic [HASH_W-1:0]    a_r;
  logic [HASH_W-1:0]    b_r;
  logic [2*HALF_LO_W-1:0] prod_r;
  logic [2*HALF_LO_W-1:0] mid_r;
  logic [2*HALF_LO_W:0]   acc_r;
  logic [HASH_W-1:0]    res_r;

  logic [HALF_LO_W-1:0]   op_x;
  logic [HALF_LO_W-1:0]   op_y;
  logic [2*HALF_LO_W-1:0] prod_nxt;
  logic [HASH_W:0]        fold_sum;
  logic [HASH_W-1:0]      fold_res;

  always_comb begin
    if (step_r == MM_HL || step_r == MM_HH) begin
      op_x = HALF_LO_W'(a_r[HASH_W-1:HALF_LO_W]);
    end else begin
      op_x = a_r[HALF_LO_W-1:0];
    end
    if (step_r == MM_LH || step_r == MM_HH) begin
      op_y = HALF_LO_W'(b_r[HASH_W-1:HALF_LO_W]);
    end else begin
      op_y = b_r[HALF_LO_W-1:0];
    end
    prod_nxt = (2*HALF_LO_W)'(op_x) * (2*HALF_LO_W)'(op_y);
  end

  always_comb begin
    fold_sum = (HASH_W+1)'(acc_r[2*HALF_LO_W:HASH_W]) + (HASH_W+1)'(acc_r[HASH_W-1:0]);
    if (fold_sum >= (HASH_W+1)'(MOD_P)) begin
      fold_res = HASH_W'(fold_sum - (HASH_W+1)'(MOD_P));
    end else begin
      fold_res = fold_sum[HASH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= MM_LL;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= MM_LL;
      end else if (busy_r) begin
        step_r <= step_r + 3'd1;
        if (step_r == MM_FOLD) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end else if (busy_r) begin
      prod_r <= prod_nxt;
      case (step_r)
        MM_LH:   acc_r <= {1'b0, prod_r};
        MM_HL:   mid_r <= prod_r;
        MM_HH:   mid_r <= mid_r + prod_r;
        MM_ACC:  acc_r <= acc_r + {1'b0, prod_r[2*HALF_LO_W-2:0], 1'b0};
        MM_MID:  acc_r <= acc_r + (2*HALF_LO_W+1)'(mid_r[2*HALF_LO_W-1:MID_LO_W])
                        + (2*HALF_LO_W+1)'({mid_r[MID_LO_W-1:0], {HALF_LO_W{1'b0}}});
        MM_FOLD: res_r <= fold_res;
        default: ;
      endcase
    end
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

### hdl/mrh_queue.sv
// ----------------------------------------------------------------------------
// mrh_queue
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module mrh_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  mrh_pkg::queue_ctl_t ctl,
  input  mrh_pkg::cmd_t       push_cmd,
  output mrh_pkg::queue_sts_t sts,
  output mrh_pkg::cmd_t       head
);
  import mrh_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push;
  logic             do_pop;

  assign sts.full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign sts.empty = (count_r == '0);
  assign head      = slot_r[rd_ptr_r];
  assign do_push   = ctl.push && !sts.full;
  assign do_pop    = ctl.pop && !sts.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### hdl/mrh_front.sv
// ----------------------------------------------------------------------------
// mrh_front
// accepts requests, tracks the string length and classifies each request
// ----------------------------------------------------------------------------
module mrh_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  mrh_pkg::in_item_t in_item,
  input  logic             queue_full,
  output logic             push,
  output mrh_pkg::cmd_t    cmd
);
  import mrh_pkg::*;

  logic [IDX_W-1:0] len_r;
  logic [IDX_W-1:0] len_nxt;
  logic             accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign push     = accept;

  always_comb begin
    len_nxt    = len_r;
    cmd.kind   = CMD_REPLY;
    cmd.symbol = in_item.symbol;
    cmd.pos    = len_r[ADDR_W-1:0];
    cmd.left   = in_item.left;
    cmd.right  = in_item.right;
    cmd.span   = in_item.right - in_item.left;
    cmd.status = ST_OK;
    unique case (in_item.func)
      FUNC_CLEAR: begin
        cmd.kind = CMD_CLEAR;
        len_nxt  = '0;
      end
      FUNC_APPEND: begin
        if (len_r >= IDX_W'(MAX_LEN)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind = CMD_APPEND;
          len_nxt  = len_r + IDX_W'(1);
        end
      end
      FUNC_QUERY: begin
        if (in_item.left > in_item.right || in_item.right > len_r) begin
          cmd.status = ST_RANGE;
        end else begin
          cmd.kind = CMD_QUERY;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (accept) begin
      len_r <= len_nxt;
    end
  end

endmodule

### hdl/mrh_back.sv
// ----------------------------------------------------------------------------
// mrh_back
// executes queued commands against the hash and power stores
// ----------------------------------------------------------------------------
module mrh_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mrh_pkg::HASH_W-1:0] base,
  input  logic                       queue_empty,
  input  mrh_pkg::cmd_t              head,
  output logic                       pop,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mrh_pkg::out_item_t         out_item
);
  import mrh_pkg::*;

  bk_state_t         state_r;
  bk_state_t         state_nxt;
  cmd_t              cmd_r;
  logic [HASH_W-1:0] last_h_r;
  logic [HASH_W-1:0] last_p_r;
  logic [HASH_W-1:0] h_right_r;
  out_item_t         res_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic              mul0_start;
  logic              mul1_start;
  logic [HASH_W-1:0] mul0_a;
  logic [HASH_W-1:0] mul0_b;
  logic              mul0_done;
  logic              mul1_done;
  logic [HASH_W-1:0] mul0_res;
  logic [HASH_W-1:0] mul1_res;

  logic              store_we;
  logic [ADDR_W-1:0] h_raddr;
  logic [ADDR_W-1:0] p_raddr;
  logic [HASH_W-1:0] h_rdata;
  logic [HASH_W-1:0] p_rdata;
  logic              load_out;

  logic [IDX_W-1:0]  left_m1;
  logic [IDX_W-1:0]  span_m1;
  logic [IDX_W-1:0]  right_m1;
  logic [HASH_W:0]   app_sum;
  logic [HASH_W-1:0] app_hv;
  logic [HASH_W:0]   q_sum;
  logic [HASH_W-1:0] q_hv;

  mrh_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_hash_ram (
    .clk     (clk),
    .we      (store_we),
    .waddr   (cmd_r.pos),
    .wdata   (app_hv),
    .raddr   (h_raddr),
    .rdata_r (h_rdata)
  );

  mrh_ram #(.WIDTH(HASH_W), .DEPTH(MAX_LEN)) u_pow_ram (
    .clk     (clk),
    .we      (store_we),
    .waddr   (cmd_r.pos),
    .wdata   (mul1_res),
    .raddr   (p_raddr),
    .rdata_r (p_rdata)
  );

  mrh_mulmod u_mul0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul0_start),
    .a      (mul0_a),
    .b      (mul0_b),
    .done   (mul0_done),
    .result (mul0_res)
  );

  mrh_mulmod u_mul1 (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul1_start),
    .a      (last_p_r),
    .b      (base),
    .done   (mul1_done),
    .result (mul1_res)
  );

  // entry k of a store sits at address k-1, entry zero is a constant
  assign left_m1  = head.left - IDX_W'(1);
  assign span_m1  = head.span - IDX_W'(1);
  assign right_m1 = cmd_r.right - IDX_W'(1);

  always_comb begin
    app_sum = (HASH_W+1)'(mul0_res) + (HASH_W+1)'(cmd_r.symbol);
    if (app_sum >= (HASH_W+1)'(MOD_P)) begin
      app_hv = HASH_W'(app_sum - (HASH_W+1)'(MOD_P));
    end else begin
      app_hv = app_sum[HASH_W-1:0];
    end
    if (h_right_r >= mul0_res) begin
      q_sum = (HASH_W+1)'(h_right_r) - (HASH_W+1)'(mul0_res);
    end else begin
      q_sum = (HASH_W+1)'(h_right_r) + (HASH_W+1)'(MOD_P) - (HASH_W+1)'(mul0_res);
    end
    q_hv = q_sum[HASH_W-1:0];
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!queue_empty) begin
          unique case (head.kind)
            CMD_APPEND: state_nxt = BK_MUL;
            CMD_QUERY:  state_nxt = BK_QREAD;
            default:    state_nxt = BK_OUT;
          endcase
        end
      end
      BK_QREAD:  state_nxt = BK_QREAD2;
      BK_QREAD2: state_nxt = BK_MUL;
      BK_MUL: begin
        if (mul0_done) begin
          state_nxt = BK_OUT;
        end
      end
      BK_OUT: begin
        if (load_out) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    pop        = 1'b0;
    mul0_start = 1'b0;
    mul1_start = 1'b0;
    mul0_a     = last_h_r;
    mul0_b     = base;
    store_we   = 1'b0;
    h_raddr    = left_m1[ADDR_W-1:0];
    p_raddr    = span_m1[ADDR_W-1:0];
    load_out   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!queue_empty) begin
          pop = 1'b1;
          if (head.kind == CMD_APPEND) begin
            mul0_start = 1'b1;
            mul1_start = 1'b1;
          end
        end
      end
      BK_QREAD: begin
        mul0_start = 1'b1;
        mul0_a     = (cmd_r.left == '0) ? '0 : h_rdata;
        mul0_b     = (cmd_r.span == '0) ? HASH_W'(1) : p_rdata;
        h_raddr    = right_m1[ADDR_W-1:0];
      end
      BK_MUL: begin
        store_we = mul0_done && mul1_done && (cmd_r.kind == CMD_APPEND);
      end
      BK_OUT: begin
        load_out = !out_valid_r || !out_stall;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      last_h_r    <= '0;
      last_p_r    <= HASH_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (pop && head.kind == CMD_CLEAR) begin
        last_h_r <= '0;
        last_p_r <= HASH_W'(1);
      end else if (store_we) begin
        last_h_r <= app_hv;
        last_p_r <= mul1_res;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r             <= head;
      res_r.hash_value  <= '0;
      res_r.status      <= head.status;
    end
    if (state_r == BK_QREAD2) begin
      h_right_r <= (cmd_r.right == '0) ? '0 : h_rdata;
    end
    if (state_r == BK_MUL && mul0_done) begin
      res_r.hash_value <= (cmd_r.kind == CMD_APPEND) ? app_hv : q_hv;
      res_r.status     <= ST_OK;
    end
    if (load_out) begin
      out_item_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

### hdl/mersenne61_rolling_hash_table.sv
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash_table
// polynomial rolling hash of a byte string modulo 2^61-1
// ----------------------------------------------------------------------------
// requests enter on in_valid/in_stall with in_item: clear, append a byte, or
// query the hash of [left,right). each request yields one result on
// out_valid/out_stall carrying hash_value and status.
// cfg_wr_en/cfg_wr_data write the base; the user must do so only while no
// request is in flight, since the block itself does not enforce it.
// a request sits in a two-entry queue; in_stall rises only when it is full.
// each modular product runs on a 31x31 multiplier as four partial
// products, two accumulate steps and a fold. append runs its hash and
// power products side by side, query reads both stores before its product
// and subtracts after it. one request is executed at a time, and the next
// one waits in the queue while the current one is executed.
// a stalled result is held in the output register while the next request
// is already executed; that request then waits for the register to free.
// synchronous reset empties the queue, drops any pending result, sets the
// string length to zero and the base to one. no clearing pass is needed.
// ----------------------------------------------------------------------------
module mersenne61_rolling_hash_table (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  mrh_pkg::in_item_t          in_item,
  output logic                       out_valid,
  input  logic                       out_stall,
  output mrh_pkg::out_item_t         out_item,
  input  logic                       cfg_wr_en,
  input  logic [mrh_pkg::HASH_W-1:0] cfg_wr_data
);
  import mrh_pkg::*;

  logic [HASH_W-1:0] base_r;
  logic [HASH_W-1:0] base_nxt;
  queue_ctl_t        q_ctl;
  queue_sts_t        q_sts;
  cmd_t              push_cmd;
  cmd_t              head;

  // the all-ones pattern is the modulus itself and acts as base zero
  assign base_nxt = (cfg_wr_data == MOD_P) ? '0 : cfg_wr_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= HASH_W'(1);
    end else if (cfg_wr_en) begin
      base_r <= base_nxt;
    end
  end

  mrh_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .queue_full (q_sts.full),
    .push       (q_ctl.push),
    .cmd        (push_cmd)
  );

  mrh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (q_ctl),
    .push_cmd (push_cmd),
    .sts      (q_sts),
    .head     (head)
  );

  mrh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .base        (base_r),
    .queue_empty (q_sts.empty),
    .head        (head),
    .pop         (q_ctl.pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item)
  );

endmodule

### hdl/mrh_checker.sv
// ----------------------------------------------------------------------------
// mrh_checker
// port-level checks of the rolling hash table, bound to the top level
// ----------------------------------------------------------------------------
module mrh_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input mrh_pkg::out_item_t out_item
);
  import mrh_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_item))
    else $error("stalled result changed");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == ST_FULL || out_item.status == ST_RANGE)
      |-> out_item.hash_value == '0)
    else $error("rejected request returned a nonzero hash");

  a_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.hash_value != MOD_P &&
      (out_item.status == ST_OK || out_item.status == ST_FULL ||
       out_item.status == ST_RANGE))
    else $error("hash not reduced or status code unknown");

endmodule

bind mersenne61_rolling_hash_table mrh_checker u_mrh_checker (.*);

### tb/mersenne61_rolling_hash_table_test.sv
// ----------------------------------------------------------------------------
// mersenne61_rolling_hash_table_test
// self-checking bench for the mod 2^61-1 rolling hash table
// ----------------------------------------------------------------------------
// a driver feeds queued requests with random gaps and a monitor takes results
// with random stalls, including one long hold that backs the block up. every
// accepted request is run through a local hash table model and the reply is
// compared field by field. phases cover directed corner cases, several bases
// (one, p-1, p, zero, random) and base changes mid-string.
// ----------------------------------------------------------------------------
module mersenne61_rolling_hash_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrh_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int IDX_MAX = (1 << IDX_W) - 1;
  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_AT_REPLY = 150;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [HASH_W-1:0] cfg_wr_data = '0;

  // model of the hash table
  logic [HASH_W-1:0] pfx_hash [0:MAX_LEN];
  logic [HASH_W-1:0] base_pow [0:MAX_LEN];
  int unsigned str_len;
  logic [HASH_W-1:0] cur_base;

  in_item_t pending_requests[$];
  out_item_t expected_replies[$];
  int unsigned gen_len;
  bit calm = 1'b0;
  bit holding = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int replies_seen = 0;
  int err_cnt = 0;
  out_item_t want;

  mersenne61_rolling_hash_table u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  function automatic logic [HASH_W-1:0] mod_mul(input logic [HASH_W-1:0] a,
                                                input logic [HASH_W-1:0] b);
    logic [2*HASH_W-1:0] prod;
    logic [HASH_W:0] s;
    prod = (2*HASH_W)'(a) * (2*HASH_W)'(b);
    s = {1'b0, prod[HASH_W-1:0]} + {1'b0, prod[2*HASH_W-1:HASH_W]};
    s = {1'b0, s[HASH_W-1:0]} + (HASH_W+1)'(s[HASH_W]);
    if (s >= {1'b0, MOD_P}) s = s - {1'b0, MOD_P};
    return s[HASH_W-1:0];
  endfunction

  task automatic hash_request(input in_item_t rq);
    out_item_t rp;
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] t;
    logic [HASH_W:0] x;
    rp = '0;
    b = (cur_base == MOD_P) ? '0 : cur_base;
    case (rq.func)
      FUNC_CLEAR: begin
        str_len = 0;
      end
      FUNC_APPEND: begin
        if (str_len >= MAX_LEN) begin
          rp.status = ST_FULL;
        end else begin
          x = {1'b0, mod_mul(pfx_hash[str_len], b)} + (HASH_W+1)'(rq.symbol);
          if (x >= {1'b0, MOD_P}) x = x - {1'b0, MOD_P};
          rp.hash_value = x[HASH_W-1:0];
          pfx_hash[str_len + 1] = x[HASH_W-1:0];
          base_pow[str_len + 1] = mod_mul(base_pow[str_len], b);
          str_len++;
        end
      end
      FUNC_QUERY: begin
        if (rq.left > rq.right || rq.right > str_len) begin
          rp.status = ST_RANGE;
        end else begin
          h = pfx_hash[rq.right];
          t = mod_mul(pfx_hash[rq.left], base_pow[rq.right - rq.left]);
          rp.hash_value = (h >= t) ? (h - t) : (h + (MOD_P - t));
        end
      end
      default: ;
    endcase
    expected_replies.insert(expected_replies.size(), rp);
  endtask

  function automatic int draw_idle();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) hash_request(in_item);
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_requests.size() != 0) begin
          in_item <= pending_requests.pop_front();
          in_valid <= 1'b1;
          gap_left = draw_idle();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected result hash_value %0h status %0d",
                 out_item.hash_value, out_item.status);
          err_cnt++;
        end else begin
          want = expected_replies.pop_front();
          if (out_item.hash_value !== want.hash_value) begin
            $error("hash_value expected %0h actual %0h", want.hash_value,
                   out_item.hash_value);
            err_cnt++;
          end
          if (out_item.status !== want.status) begin
            $error("status expected %0d actual %0d", want.status, out_item.status);
            err_cnt++;
          end
        end
        replies_seen++;
        stall_left = draw_idle();
      end
      if (holding) begin
        out_stall <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // long receiver hold so the block backs up
  initial begin
    wait (replies_seen == HOLD_AT_REPLY);
    @(negedge clk);
    holding = 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    holding = 1'b0;
  end

  task automatic push_req(input logic [FUNC_W-1:0] func, input int sym, input int lft,
                          input int rgt);
    in_item_t rq;
    rq.func = func;
    rq.symbol = sym[SYM_W-1:0];
    rq.left = lft[IDX_W-1:0];
    rq.right = rgt[IDX_W-1:0];
    case (func)
      FUNC_CLEAR: gen_len = 0;
      FUNC_APPEND: if (gen_len < MAX_LEN) gen_len++;
      default: ;
    endcase
    pending_requests.insert(pending_requests.size(), rq);
  endtask

  task automatic queue_random(input int n);
    int pick;
    int f;
    int sym;
    int lft;
    int rgt;
    repeat (n) begin
      f = $urandom_range(0, 3);
      sym = $urandom_range(0, 255);
      lft = $urandom_range(0, IDX_MAX);
      rgt = $urandom_range(0, IDX_MAX);
      pick = $urandom_range(0, 99);
      if (pick < 5) begin
        f = FUNC_CLEAR;
      end else if (pick < 45) begin
        f = FUNC_APPEND;
      end else if (pick < 85) begin
        f = FUNC_QUERY;
        rgt = $urandom_range(0, gen_len);
        lft = $urandom_range(0, rgt);
      end else if (pick < 92) begin
        f = FUNC_QUERY;
        if ($urandom_range(0, 1)) begin
          rgt = $urandom_range(gen_len + 1, IDX_MAX);
        end else begin
          rgt = $urandom_range(0, IDX_MAX - 1);
          lft = $urandom_range(rgt + 1, IDX_MAX);
        end
      end else if (pick < 96) begin
        f = FUNC_UNUSED;
      end
      push_req(f[FUNC_W-1:0], sym, lft, rgt);
    end
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_requests.size() != 0 || in_valid || expected_replies.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_base(input logic [HASH_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    cur_base = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [63:0] r64;
    pfx_hash[0] = '0;
    base_pow[0] = HASH_W'(1);
    str_len = 0;
    cur_base = HASH_W'(1);
    gen_len = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corner cases at the reset base
    push_req(FUNC_QUERY, 0, 0, 0);
    push_req(FUNC_QUERY, 0, 0, 1);
    push_req(FUNC_APPEND, 8'h00, 0, 0);
    push_req(FUNC_APPEND, 8'hff, 0, 0);
    push_req(FUNC_APPEND, 8'h80, 0, 0);
    push_req(FUNC_QUERY, 0, 0, 3);
    push_req(FUNC_QUERY, 8'hff, 1, 3);
    push_req(FUNC_QUERY, 0, 3, 3);
    push_req(FUNC_QUERY, 0, 2, 1);
    push_req(FUNC_QUERY, 0, IDX_MAX, IDX_MAX);
    push_req(FUNC_QUERY, 0, 0, IDX_MAX);
    push_req(FUNC_UNUSED, 8'hff, IDX_MAX, IDX_MAX);
    push_req(FUNC_CLEAR, 8'hff, IDX_MAX, IDX_MAX);
    push_req(FUNC_QUERY, 0, 0, 1);
    push_req(FUNC_APPEND, 8'h5a, IDX_MAX, IDX_MAX);
    push_req(FUNC_QUERY, 0, 0, 1);
    drain();

    set_base(MOD_P - 1);
    queue_random(200);
    drain();

    // all ones reduces to base zero
    set_base(MOD_P);
    queue_random(60);
    drain();

    set_base('0);
    queue_random(40);
    drain();

    r64 = {$urandom, $urandom};
    set_base(r64[HASH_W-1:0]);
    calm = 1'b1;
    queue_random(80);
    drain();
    calm = 1'b0;

    r64 = {$urandom, $urandom};
    set_base(r64[HASH_W-1:0]);
    queue_random(150);
    drain();

    set_base(HASH_W'(1));
    queue_random(60);
    drain();

    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #(600_000 * 12);
    $display("TB_ERROR");
    $finish;
  end

endmodule
